@@ sv/srsp_pkg.sv @@
package srsp_pkg;

   localparam logic [4:0] PH_MAGIC    = 5'd0;
   localparam logic [4:0] PH_MARKER   = 5'd1;
   localparam logic [4:0] PH_NSLEN    = 5'd2;
   localparam logic [4:0] PH_NSBYTE   = 5'd3;
   localparam logic [4:0] PH_DB       = 5'd4;
   localparam logic [4:0] PH_KEYLEN   = 5'd5;
   localparam logic [4:0] PH_KEYBYTE  = 5'd6;
   localparam logic [4:0] PH_EXP      = 5'd7;
   localparam logic [4:0] PH_KIND     = 5'd8;
   localparam logic [4:0] PH_INT      = 5'd9;
   localparam logic [4:0] PH_COUNT    = 5'd10;
   localparam logic [4:0] PH_ITEMLEN  = 5'd11;
   localparam logic [4:0] PH_ITEMBYTE = 5'd12;
   localparam logic [4:0] PH_SCORE    = 5'd13;
   localparam logic [4:0] PH_IDLE     = 5'd14;

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_OK    = 3'd1;
   localparam logic [2:0] ST_MAGIC = 3'd2;
   localparam logic [2:0] ST_MARK  = 3'd3;
   localparam logic [2:0] ST_KIND  = 3'd4;
   localparam logic [2:0] ST_TRUNC = 3'd5;

   localparam logic [3:0] ROLE_MAGIC    = 4'd0;
   localparam logic [3:0] ROLE_MARKER   = 4'd1;
   localparam logic [3:0] ROLE_NSLEN    = 4'd2;
   localparam logic [3:0] ROLE_NSBYTE   = 4'd3;
   localparam logic [3:0] ROLE_DB       = 4'd4;
   localparam logic [3:0] ROLE_KEYLEN   = 4'd5;
   localparam logic [3:0] ROLE_KEYBYTE  = 4'd6;
   localparam logic [3:0] ROLE_EXPIRY   = 4'd7;
   localparam logic [3:0] ROLE_KIND     = 4'd8;
   localparam logic [3:0] ROLE_INT      = 4'd9;
   localparam logic [3:0] ROLE_COUNT    = 4'd10;
   localparam logic [3:0] ROLE_ITEMLEN  = 4'd11;
   localparam logic [3:0] ROLE_ITEMBYTE = 4'd12;
   localparam logic [3:0] ROLE_SCORE    = 4'd13;
   localparam logic [3:0] ROLE_IGNORED = 4'd15;
   localparam logic [3:0] ROLE_END     = 4'd14;
   localparam logic [7:0] MARK_REC     = 8'h01;
   localparam logic [7:0] MARK_END     = 8'hFF;
   localparam logic [2:0] KIND_INT     = 3'd0;
   localparam logic [2:0] KIND_STR     = 3'd1;
   localparam logic [2:0] KIND_HASH    = 3'd3;
   localparam logic [2:0] KIND_ZSET    = 3'd5;

   localparam int unsigned QDEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  byte_role;
      logic [7:0]  byte_echo;
      logic [63:0] field_value;
      logic        field_complete;
      logic        pair_value_part;
      logic        record_complete;
      logic [2:0]  parse_status;
   } rsp_type;

   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h49;
         3'd1: c = 8'h4D;
         3'd2: c = 8'h44;
         3'd3: c = 8'h52;
         3'd4: c = 8'h44;
         3'd5: c = 8'h42;
         3'd6: c = 8'h30;
         default: c = 8'h32;
      endcase
      return c;
   endfunction

endpackage

@@ sv/srsp_if.sv @@
interface srsp_req_if import srsp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface srsp_rsp_if import srsp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/snapshot_record_stream_parser_top.sv @@
// channel | dir | handshake          | payload
// req     | in  | req_valid/req_ready | data_byte, first_byte, last_byte
// rsp     | out | rsp_valid/rsp_ready | role, echo, field value, flags, status
// One transaction in, one out, one byte per cycle sustained while rsp_ready stays high.
// A request is registered in the queue entry, then the parse step registers the result.
// The parse state register updates as each byte leaves the queue; the output holds on stall.
// A full two-entry queue drops req_ready until the output drains.
// Reset is synchronous and returns the parser to the magic check with running status.
module snapshot_record_stream_parser_top import srsp_pkg::*; (
   input logic clock,
   input logic reset,
   srsp_req_if.sink   req,
   srsp_rsp_if.source rsp
);
   logic    q_valid, q_ready;
   req_type q_data;

   srsp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   srsp_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );
endmodule

@@ sv/srsp_front.sv @@
module srsp_front import srsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    q_valid,
   input  logic    q_ready,
   output req_type q_data
);
   req_type q_ff [QDEPTH];
   req_type q_in [QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'(QDEPTH));
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_data = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         q_in[1'(cnt_ff - {1'b0, pop})] = in_data;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDEPTH)) else $error("queue overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("bad count");
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> $stable(q_data)) else $error("head changed");
`endif
endmodule

@@ sv/srsp_back.sv @@
module srsp_back import srsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_ready,
   input  req_type q_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] rlen_ff, rlen_in;
   logic [31:0] ritems_ff, ritems_in;
   logic [63:0] acc_ff, acc_in;
   logic [2:0]  kind_ff, kind_in;
   logic        half_ff, half_in;
   logic [2:0]  stat_ff, stat_in;
   logic        ov_ff;
   rsp_type     od_ff, od_in;
   logic        step;

   logic [7:0]  b;
   logic [63:0] nacc;
   logic [3:0]  ncnt;
   logic [3:0]  need;
   logic        ndone;
   logic        rec_end;
   logic [4:0]  ph;
   logic [2:0]  st;
   logic [31:0] rl, ri;
   logic [2:0]  kd;
   logic        hf;
   logic [63:0] ac;
   logic [3:0]  ct;
   logic        numph;

   assign q_ready = !ov_ff || out_ready;
   assign step = q_valid && q_ready;
   assign out_valid = ov_ff;
   assign out_data = od_ff;

   always_comb begin
      b = q_data.data_byte;
      if (q_data.first_byte) begin
         ph = PH_MAGIC; ct = 4'd0; rl = 32'd0; ri = 32'd0; ac = 64'd0;
         kd = 3'd0; hf = 1'b0; st = ST_RUN;
      end else begin
         ph = phase_ff; ct = cnt_ff; rl = rlen_ff; ri = ritems_ff; ac = acc_ff;
         kd = kind_ff; hf = half_ff; st = stat_ff;
      end
      nacc = ac | ({56'd0, b} << {ct[2:0], 3'b000});
      ncnt = ct + 4'd1;
      case (ph)
         PH_EXP, PH_INT, PH_SCORE: need = 4'd8;
         default: need = 4'd4;
      endcase
      numph = (ph == PH_NSLEN) || (ph == PH_KEYLEN) || (ph == PH_DB) ||
              (ph == PH_EXP) || (ph == PH_INT) || (ph == PH_COUNT) ||
              (ph == PH_ITEMLEN) || (ph == PH_SCORE);
      ndone = numph && (ncnt >= need);

      od_in = '0;
      od_in.byte_role = ROLE_IGNORED;
      od_in.byte_echo = b;
      rec_end = 1'b0;
      phase_in = ph; cnt_in = ct; rlen_in = rl; ritems_in = ri; acc_in = ac;
      kind_in = kd; half_in = hf; stat_in = st;

      if (st == ST_RUN) begin
         if (numph) begin
            if (ndone) begin
               acc_in = 64'd0;
               cnt_in = 4'd0;
               od_in.field_complete = 1'b1;
               od_in.field_value = nacc;
            end else begin
               acc_in = nacc;
               cnt_in = ncnt;
            end
         end
         case (ph)
            PH_MAGIC: begin
               od_in.byte_role = ROLE_MAGIC;
               if (b != magic_char(ct[2:0])) begin
                  stat_in = ST_MAGIC;
                  cnt_in = 4'd0;
               end else if (ncnt >= 4'd8) begin
                  cnt_in = 4'd0;
                  phase_in = PH_MARKER;
               end else begin
                  cnt_in = ncnt;
               end
            end
            PH_MARKER: begin
               if (b == MARK_END) begin
                  od_in.byte_role = ROLE_END;
                  stat_in = ST_OK;
               end else begin
                  od_in.byte_role = ROLE_MARKER;
                  if (b == MARK_REC) begin
                     phase_in = PH_NSLEN;
                  end else begin
                     stat_in = ST_MARK;
                  end
               end
            end
            PH_NSLEN, PH_KEYLEN: begin
               od_in.byte_role = (ph == PH_NSLEN) ? ROLE_NSLEN : ROLE_KEYLEN;
               if (ndone) begin
                  rlen_in = nacc[31:0];
                  if (ph == PH_NSLEN) begin
                     phase_in = (nacc[31:0] != 32'd0) ? PH_NSBYTE : PH_DB;
                  end else begin
                     phase_in = (nacc[31:0] != 32'd0) ? PH_KEYBYTE : PH_EXP;
                  end
               end
            end
            PH_NSBYTE, PH_KEYBYTE: begin
               od_in.byte_role = (ph == PH_NSBYTE) ? ROLE_NSBYTE : ROLE_KEYBYTE;
               rlen_in = rl - 32'd1;
               if (rl == 32'd1) begin
                  phase_in = (ph == PH_NSBYTE) ? PH_DB : PH_EXP;
               end
            end
            PH_DB: begin
               od_in.byte_role = ROLE_DB;
               if (ndone) phase_in = PH_KEYLEN;
            end
            PH_EXP: begin
               od_in.byte_role = ROLE_EXPIRY;
               if (ndone) phase_in = PH_KIND;
            end
            PH_KIND: begin
               od_in.byte_role = ROLE_KIND;
               half_in = 1'b0;
               if (b > {5'd0, KIND_ZSET}) begin
                  stat_in = ST_KIND;
               end else begin
                  kind_in = b[2:0];
                  if (b[2:0] == KIND_INT) begin
                     phase_in = PH_INT;
                  end else if (b[2:0] == KIND_STR) begin
                     ritems_in = 32'd1;
                     phase_in = PH_ITEMLEN;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
            end
            PH_INT: begin
               od_in.byte_role = ROLE_INT;
               if (ndone) rec_end = 1'b1;
            end
            PH_COUNT: begin
               od_in.byte_role = ROLE_COUNT;
               if (ndone) begin
                  ritems_in = nacc[31:0];
                  if (nacc[31:0] == 32'd0) rec_end = 1'b1;
                  else phase_in = PH_ITEMLEN;
               end
            end
            PH_ITEMLEN, PH_ITEMBYTE: begin
               od_in.byte_role = (ph == PH_ITEMLEN) ? ROLE_ITEMLEN : ROLE_ITEMBYTE;
               od_in.pair_value_part = (kd == KIND_HASH) && hf;
               if (ph == PH_ITEMLEN) begin
                  if (ndone) begin
                     rlen_in = nacc[31:0];
                     if (nacc[31:0] != 32'd0) phase_in = PH_ITEMBYTE;
                  end
               end else begin
                  rlen_in = rl - 32'd1;
               end
               if ((ph == PH_ITEMLEN && ndone && nacc[31:0] == 32'd0) ||
                   (ph == PH_ITEMBYTE && rl == 32'd1)) begin
                  if (kd == KIND_ZSET) begin
                     phase_in = PH_SCORE;
                  end else if (kd == KIND_HASH && !hf) begin
                     half_in = 1'b1;
                     phase_in = PH_ITEMLEN;
                  end else begin
                     half_in = 1'b0;
                     ritems_in = ri - 32'd1;
                     if (ri == 32'd1) rec_end = 1'b1;
                     else phase_in = PH_ITEMLEN;
                  end
               end
            end
            PH_SCORE: begin
               od_in.byte_role = ROLE_SCORE;
               if (ndone) begin
                  ritems_in = ri - 32'd1;
                  if (ri == 32'd1) rec_end = 1'b1;
                  else phase_in = PH_ITEMLEN;
               end
            end
            default: od_in.byte_role = ROLE_IGNORED;
         endcase
         if (rec_end) phase_in = PH_MARKER;
         if (stat_in == ST_RUN && q_data.last_byte) begin
            if (phase_in == PH_MAGIC) stat_in = ST_MAGIC;
            else if (phase_in == PH_MARKER) stat_in = ST_OK;
            else stat_in = ST_TRUNC;
         end
         if (stat_in != ST_RUN) begin
            phase_in = PH_IDLE;
            cnt_in = 4'd0;
            acc_in = 64'd0;
         end
      end
      od_in.record_complete = rec_end;
      od_in.parse_status = stat_in;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         od_ff <= od_in;
      end
      if (reset) begin
         ov_ff <= 1'b0;
         phase_ff <= PH_MAGIC;
         cnt_ff <= 4'd0;
         stat_ff <= ST_RUN;
         rlen_ff <= 32'd0;
         ritems_ff <= 32'd0;
         acc_ff <= 64'd0;
         kind_ff <= 3'd0;
         half_ff <= 1'b0;
      end else if (step) begin
         ov_ff <= 1'b1;
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         stat_ff <= stat_in;
         rlen_ff <= rlen_in;
         ritems_ff <= ritems_in;
         acc_ff <= acc_in;
         kind_ff <= kind_in;
         half_ff <= half_in;
      end else if (out_ready) begin
         ov_ff <= 1'b0;
      end
   end

`ifndef ASSERT_OFF
   a_idle_sticky: assert property (@(posedge clock) disable iff (reset)
      stat_ff != ST_RUN |-> phase_ff == PH_IDLE) else $error("stopped but active");
   a_cnt_low: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < 4'd8) else $error("byte counter overrun");
   a_stop_ignored: assert property (@(posedge clock) disable iff (reset)
      step && stat_ff != ST_RUN && !q_data.first_byte |=>
      out_data.byte_role == ROLE_IGNORED) else $error("role after stop");
`endif
endmodule

@@ tb/srsp_parse_checker.sv @@
module srsp_parse_checker import srsp_pkg::*; (
   input  logic clock,
   input  logic reset,
   srsp_req_if  req,
   srsp_rsp_if  rsp,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] MAGIC_WORD = "IMDRDB02";

   logic [4:0]  phase;
   logic [3:0]  idx;
   logic [31:0] str_left;
   logic [31:0] items_left;
   logic [63:0] acc;
   logic [2:0]  kind;
   logic        second_half;
   logic [2:0]  status;

   rsp_type parsed_q[$];

   function automatic void restart_parse();
      phase = PH_MAGIC;
      idx = 4'd0;
      str_left = 32'd0;
      items_left = 32'd0;
      acc = 64'd0;
      kind = 3'd0;
      second_half = 1'b0;
      status = ST_RUN;
   endfunction

   function automatic logic take_field(input logic [7:0] b, input int n,
                                       output logic [63:0] v);
      acc = acc | (64'(b) << (8 * idx[2:0]));
      idx = idx + 4'd1;
      v = 64'd0;
      if (idx >= n) begin
         v = acc;
         acc = 64'd0;
         idx = 4'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic close_item();
      if (kind == KIND_ZSET) begin
         phase = PH_SCORE;
         return 1'b0;
      end
      if (kind == KIND_HASH && !second_half) begin
         second_half = 1'b1;
         phase = PH_ITEMLEN;
         return 1'b0;
      end
      second_half = 1'b0;
      items_left = items_left - 32'd1;
      if (items_left == 32'd0) return 1'b1;
      phase = PH_ITEMLEN;
      return 1'b0;
   endfunction

   function automatic rsp_type parse_byte(input req_type t);
      rsp_type     r;
      logic [7:0]  b;
      logic [63:0] v;
      logic        done;
      logic        rec_end;
      b = t.data_byte;
      r = '0;
      r.byte_role = ROLE_IGNORED;
      r.byte_echo = b;
      done = 1'b0;
      rec_end = 1'b0;
      v = 64'd0;
      if (t.first_byte) restart_parse();
      if (status == ST_RUN) begin
         case (phase)
            PH_MAGIC: begin
               r.byte_role = ROLE_MAGIC;
               if (b != MAGIC_WORD[63 - 8 * idx[2:0] -: 8]) begin
                  status = ST_MAGIC;
                  idx = 4'd0;
               end else begin
                  idx = idx + 4'd1;
                  if (idx >= 4'd8) begin
                     idx = 4'd0;
                     phase = PH_MARKER;
                  end
               end
            end
            PH_MARKER: begin
               if (b == MARK_END) begin
                  r.byte_role = ROLE_END;
                  status = ST_OK;
               end else begin
                  r.byte_role = ROLE_MARKER;
                  if (b == MARK_REC) phase = PH_NSLEN;
                  else status = ST_MARK;
               end
            end
            PH_NSLEN, PH_KEYLEN: begin
               r.byte_role = (phase == PH_NSLEN) ? ROLE_NSLEN : ROLE_KEYLEN;
               done = take_field(b, 4, v);
               if (done) begin
                  str_left = v[31:0];
                  if (phase == PH_NSLEN) phase = (str_left != 0) ? PH_NSBYTE : PH_DB;
                  else phase = (str_left != 0) ? PH_KEYBYTE : PH_EXP;
               end
            end
            PH_NSBYTE, PH_KEYBYTE: begin
               r.byte_role = (phase == PH_NSBYTE) ? ROLE_NSBYTE : ROLE_KEYBYTE;
               str_left = str_left - 32'd1;
               if (str_left == 0) phase = (phase == PH_NSBYTE) ? PH_DB : PH_EXP;
            end
            PH_DB: begin
               r.byte_role = ROLE_DB;
               done = take_field(b, 4, v);
               if (done) phase = PH_KEYLEN;
            end
            PH_EXP: begin
               r.byte_role = ROLE_EXPIRY;
               done = take_field(b, 8, v);
               if (done) phase = PH_KIND;
            end
            PH_KIND: begin
               r.byte_role = ROLE_KIND;
               second_half = 1'b0;
               if (b > {5'd0, KIND_ZSET}) begin
                  status = ST_KIND;
               end else begin
                  kind = b[2:0];
                  if (kind == KIND_INT) begin
                     phase = PH_INT;
                  end else if (kind == KIND_STR) begin
                     items_left = 32'd1;
                     phase = PH_ITEMLEN;
                  end else begin
                     phase = PH_COUNT;
                  end
               end
            end
            PH_INT: begin
               r.byte_role = ROLE_INT;
               done = take_field(b, 8, v);
               rec_end = done;
            end
            PH_COUNT: begin
               r.byte_role = ROLE_COUNT;
               done = take_field(b, 4, v);
               if (done) begin
                  items_left = v[31:0];
                  if (items_left == 0) rec_end = 1'b1;
                  else phase = PH_ITEMLEN;
               end
            end
            PH_ITEMLEN: begin
               r.byte_role = ROLE_ITEMLEN;
               r.pair_value_part = (kind == KIND_HASH) && second_half;
               done = take_field(b, 4, v);
               if (done) begin
                  str_left = v[31:0];
                  if (str_left == 0) rec_end = close_item();
                  else phase = PH_ITEMBYTE;
               end
            end
            PH_ITEMBYTE: begin
               r.byte_role = ROLE_ITEMBYTE;
               r.pair_value_part = (kind == KIND_HASH) && second_half;
               str_left = str_left - 32'd1;
               if (str_left == 0) rec_end = close_item();
            end
            PH_SCORE: begin
               r.byte_role = ROLE_SCORE;
               done = take_field(b, 8, v);
               if (done) begin
                  items_left = items_left - 32'd1;
                  if (items_left == 0) rec_end = 1'b1;
                  else phase = PH_ITEMLEN;
               end
            end
            default: r.byte_role = ROLE_IGNORED;
         endcase
         if (rec_end) phase = PH_MARKER;
         if (status == ST_RUN && t.last_byte) begin
            if (phase == PH_MAGIC) status = ST_MAGIC;
            else if (phase == PH_MARKER) status = ST_OK;
            else status = ST_TRUNC;
         end
         if (status != ST_RUN) begin
            phase = PH_IDLE;
            idx = 4'd0;
            acc = 64'd0;
         end
      end
      r.field_value = done ? v : 64'd0;
      r.field_complete = done;
      r.record_complete = rec_end;
      r.parse_status = status;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   assign pending = parsed_q.size();

   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (reset) begin
         restart_parse();
         parsed_q.delete();
         fail_count = 0;
      end else begin
         if (req.valid && req.ready) parsed_q = {parsed_q, parse_byte(req.payload)};
         if (rsp.valid && rsp.ready) begin
            a = rsp.payload;
            if (parsed_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual %p", $time, a);
               fail_count++;
            end else begin
               e = parsed_q.pop_front();
               check_field("byte_role", 64'(e.byte_role), 64'(a.byte_role));
               check_field("byte_echo", 64'(e.byte_echo), 64'(a.byte_echo));
               check_field("field_value", e.field_value, a.field_value);
               check_field("field_complete", 64'(e.field_complete),
                           64'(a.field_complete));
               check_field("pair_value_part", 64'(e.pair_value_part),
                           64'(a.pair_value_part));
               check_field("record_complete", 64'(e.record_complete),
                           64'(a.record_complete));
               check_field("parse_status", 64'(e.parse_status), 64'(a.parse_status));
            end
         end
      end
   end

endmodule

@@ tb/tb_snapshot_record_stream_parser_top.sv @@
module tb_snapshot_record_stream_parser_top import srsp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   burst_left;
   int   bytes_sent;
   int   cyc = 0;
   logic drained;
   req_type file_q[$];

   srsp_req_if req ();
   srsp_rsp_if rsp ();

   snapshot_record_stream_parser_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   srsp_parse_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      case ((cyc / 300) % 3)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         default: rsp.ready <= ((cyc % 7) < 4);
      endcase
   end

   function automatic void put(input logic [7:0] b);
      req_type t;
      t.data_byte = b;
      t.first_byte = 1'b0;
      t.last_byte = 1'b0;
      file_q = {file_q, t};
   endfunction

   function automatic void put_num(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) put(v[8 * i +: 8]);
   endfunction

   function automatic void put_str(input int len);
      put_num(64'(len), 4);
      repeat (len) put(8'($urandom));
   endfunction

   function automatic void put_magic();
      logic [63:0] m;
      m = "IMDRDB02";
      for (int i = 0; i < 8; i++) put(m[63 - 8 * i -: 8]);
   endfunction

   function automatic void put_record();
      int k;
      int n;
      put(MARK_REC);
      put_str($urandom_range(0, 3));
      put_num(64'($urandom), 4);
      put_str($urandom_range(0, 3));
      put_num({$urandom, $urandom}, 8);
      k = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 255) : $urandom_range(0, 5);
      put(8'(k));
      n = $urandom_range(0, 3);
      case (k)
         0: put_num({$urandom, $urandom}, 8);
         1: put_str($urandom_range(0, 3));
         2, 3, 4, 5: begin
            put_num(64'(n), 4);
            repeat (n) begin
               put_str($urandom_range(0, 3));
               if (k == 3) put_str($urandom_range(0, 3));
               if (k == 5) put_num({$urandom, $urandom}, 8);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void build_file();
      int ending;
      int cut;
      file_q.delete();
      put_magic();
      repeat ($urandom_range(0, 3)) put_record();
      ending = $urandom_range(0, 9);
      if (ending < 4) begin
         put(MARK_END);
         repeat ($urandom_range(0, 2)) put(8'($urandom));
      end else if (ending < 7) begin
      end else if (ending < 9) begin
         cut = $urandom_range(1, file_q.size() - 1);
         while (file_q.size() > cut) void'(file_q.pop_back());
      end else begin
         file_q[$urandom_range(0, file_q.size() - 1)].data_byte = 8'($urandom);
      end
      file_q[0].first_byte = 1'b1;
      file_q[$].last_byte = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(0, file_q.size() - 1);
         file_q[cut].first_byte = 1'($urandom);
         file_q[cut].last_byte = 1'($urandom);
      end
   endfunction

   task automatic send_file();
      foreach (file_q[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
               req.valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         req.valid <= 1'b1;
         req.payload <= file_q[i];
         @(posedge clock);
         while (!req.ready) @(posedge clock);
         burst_left--;
         bytes_sent++;
      end
   endtask

   task automatic send_mark(input logic first, input logic last);
      file_q[0].first_byte = first;
      file_q[$].last_byte = last;
      send_file();
   endtask

   initial begin
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.payload <= '0;
      burst_left = 0;
      bytes_sent = 0;
      drained = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      file_q.delete();
      put_magic();
      void'(file_q.pop_back());
      send_mark(1, 1);
      file_q.delete();
      put(8'h49);
      put(8'h00);
      put(8'hFF);
      send_mark(1, 0);
      file_q.delete();
      put_magic();
      send_mark(1, 1);
      file_q.delete();
      put_magic();
      put(MARK_END);
      put(8'h55);
      send_mark(1, 0);
      file_q.delete();
      put_magic();
      put(8'h02);
      send_mark(1, 0);
      file_q.delete();
      put(MARK_REC);
      put_num(64'd0, 4);
      put_num(64'hFFFF_FFFF, 4);
      put_num(64'd0, 4);
      put_num(64'hFFFF_FFFF_FFFF_FFFF, 8);
      put(8'hFF);
      send_mark(0, 1);

      while (bytes_sent < 1250) begin
         build_file();
         send_file();
         if (!drained && bytes_sent > 600) begin
            drained = 1'b1;
            req.valid <= 1'b0;
            burst_left = 0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
